// ===== sv/bces_pkg.sv =====
package bces_pkg;

	localparam int PART_W     = 12;
	localparam int MAX_PARTS  = 4096;
	localparam int MAX_BONDS  = 16;
	localparam int SLOT_W     = 4;
	localparam int CNT_W      = 5;
	localparam int MAX_RES    = 32;
	localparam int NRES_W     = 6;
	localparam int TOTAL_W    = 16;
	localparam int CLUSTER_W  = 16;
	localparam int LABEL_W    = 2;
	localparam int STEP_W     = 3;

	localparam int IN_DATA_W  = 112;
	localparam int OUT_DATA_W = 48;

	typedef enum logic [2:0] {
		OP_CLEAR  = 3'd0,
		OP_APPEND = 3'd1,
		OP_QUERY  = 3'd2,
		OP_READ   = 3'd3,
		OP_RESET  = 3'd4
	} op_t;

	localparam logic [LABEL_W-1:0] LBL_C = 2'd0;
	localparam logic [LABEL_W-1:0] LBL_B = 2'd1;
	localparam logic [LABEL_W-1:0] LBL_O = 2'd2;

	// Label update sequence after a find.
	localparam logic [STEP_W-1:0] STEP_CAND    = 3'd0;
	localparam logic [STEP_W-1:0] STEP_RING_A  = 3'd1;
	localparam logic [STEP_W-1:0] STEP_RING_B  = 3'd2;
	localparam logic [STEP_W-1:0] STEP_RING_C  = 3'd3;
	localparam logic [STEP_W-1:0] STEP_RING_D  = 3'd4;
	localparam logic [STEP_W-1:0] STEP_SPIN_A  = 3'd5;
	localparam logic [STEP_W-1:0] STEP_SPIN_B  = 3'd6;

	typedef enum logic [14:0] {
		ST_CLR    = 15'h0001,
		ST_IDLE   = 15'h0002,
		ST_APP    = 15'h0004,
		ST_LRD    = 15'h0008,
		ST_RESP   = 15'h0010,
		ST_QCNT   = 15'h0020,
		ST_QENT   = 15'h0040,
		ST_QCAND  = 15'h0080,
		ST_QCCNT  = 15'h0100,
		ST_QWALK  = 15'h0200,
		ST_QHIT   = 15'h0400,
		ST_QLRD   = 15'h0800,
		ST_QLWR   = 15'h1000,
		ST_QFOUND = 15'h2000,
		ST_QFIN   = 15'h4000
	} state_t;

endpackage

// ===== sv/bonded_cluster_extension_search.sv =====
// Bonded cluster extension search. The block keeps a bond list of up to 16
// neighbours for each of 4096 particles and a C/B/O label per particle, all in
// on-chip synchronous memories. Requests on the input stream select the
// operation in tuser: clear a bond list, append a neighbour, query a cluster,
// read a label or reset a label. Every request except a query gives exactly one
// response with tlast set. A query walks the bond list of each spindle; each
// neighbour outside the cluster that is bonded to exactly two ring particles is
// reported as a find (tuser high), and the labels of the cluster and the find
// are updated. A query with no find gives one response with tuser low; the last
// response of a query carries tlast. At most 32 finds are reported per query,
// but the saturating find total counts every find. After reset the block clears
// the bond counts and labels, one particle a cycle, before it accepts its first
// request. Requests are handled one at a time. A query reads each spindle
// neighbour, walks the bond list of each neighbour outside the cluster, and
// updates the labels for each find; the bond table has a single read port. The
// output register lets a finished response wait while the next request enters.
module bonded_cluster_extension_search (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// particle, neighbour, cluster_index, ring_a, ring_b, ring_c, ring_d,
	// spindle_a, spindle_b (lowest bits first)
	input  logic [bces_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	// operation
	input  logic [2:0]                      s_axis_tuser,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// query_cluster, attached_particle, spindle_used, label, overflow, found_total
	// (lowest bits first)
	output logic [bces_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	// found
	output logic                            m_axis_tuser,
	output logic                            m_axis_tlast
);
	import bces_pkg::*;

	localparam int BT_DEPTH = MAX_PARTS * MAX_BONDS;
	localparam int BT_AW    = PART_W + SLOT_W;

	// Memories.
	logic [PART_W-1:0]  bt_mem  [BT_DEPTH];
	logic [CNT_W-1:0]   cnt_mem [MAX_PARTS];
	logic [LABEL_W-1:0] lbl_mem [MAX_PARTS];

	logic               bt_we;
	logic [BT_AW-1:0]   bt_waddr, bt_raddr;
	logic [PART_W-1:0]  bt_wdata, bt_rd_q;
	logic               cnt_we;
	logic [PART_W-1:0]  cnt_waddr, cnt_raddr;
	logic [CNT_W-1:0]   cnt_wdata, cnt_rd_q;
	logic               lbl_we;
	logic [PART_W-1:0]  lbl_waddr, lbl_raddr;
	logic [LABEL_W-1:0] lbl_wdata, lbl_rd_q;

	always_ff @(posedge clk) begin
		if (bt_we) begin
			bt_mem[bt_waddr] <= bt_wdata;
		end
		bt_rd_q <= bt_mem[bt_raddr];
	end

	always_ff @(posedge clk) begin
		if (cnt_we) begin
			cnt_mem[cnt_waddr] <= cnt_wdata;
		end
		cnt_rd_q <= cnt_mem[cnt_raddr];
	end

	always_ff @(posedge clk) begin
		if (lbl_we) begin
			lbl_mem[lbl_waddr] <= lbl_wdata;
		end
		lbl_rd_q <= lbl_mem[lbl_raddr];
	end

	// Request fields.
	logic [PART_W-1:0]    in_part, in_nb;
	logic [CLUSTER_W-1:0] in_qc;
	logic [PART_W-1:0]    in_cl [6];

	assign in_part = s_axis_tdata[11:0];
	assign in_nb   = s_axis_tdata[23:12];
	assign in_qc   = s_axis_tdata[39:24];
	assign in_cl[0] = s_axis_tdata[51:40];
	assign in_cl[1] = s_axis_tdata[63:52];
	assign in_cl[2] = s_axis_tdata[75:64];
	assign in_cl[3] = s_axis_tdata[87:76];
	assign in_cl[4] = s_axis_tdata[99:88];
	assign in_cl[5] = s_axis_tdata[111:100];

	state_t               state_q;
	logic [PART_W-1:0]    clr_q;
	logic [PART_W-1:0]    part_q, nb_q;
	logic [CLUSTER_W-1:0] qc_q;
	logic [PART_W-1:0]    cl_q [6];
	logic                 sidx_q;
	logic [CNT_W-1:0]     n_q, k_q, cn_q, j_q;
	logic [PART_W-1:0]    cand_q;
	logic [3:0]           hit_q;
	logic [STEP_W-1:0]    lstep_q;
	logic [NRES_W-1:0]    nres_q;
	logic                 pend_valid_q, pend_sp_q;
	logic [PART_W-1:0]    pend_cand_q;
	logic [TOTAL_W-1:0]   pend_tot_q;
	logic [TOTAL_W-1:0]   total_q;
	logic [LABEL_W-1:0]   resp_lbl_q;
	logic                 resp_ov_q;

	logic                 accept, out_free, push;
	logic [OUT_DATA_W-1:0] push_data;
	logic                 push_found, push_last;
	logic [TOTAL_W-1:0]   total_inc;
	logic                 member;
	logic [3:0]           hit_now;
	logic [PART_W-1:0]    step_part;
	logic                 found_go;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign out_free      = !m_axis_tvalid || m_axis_tready;
	assign total_inc     = (total_q == '1) ? total_q : total_q + TOTAL_W'(1);

	always_comb begin
		member = 1'b0;
		for (int i = 0; i < 6; i++) begin
			if (cl_q[i] == bt_rd_q) begin
				member = 1'b1;
			end
		end
		for (int r = 0; r < 4; r++) begin
			hit_now[r] = (cl_q[r] == bt_rd_q);
		end
	end

	always_comb begin
		case (lstep_q)
			STEP_CAND:   step_part = cand_q;
			STEP_RING_A: step_part = cl_q[0];
			STEP_RING_B: step_part = cl_q[1];
			STEP_RING_C: step_part = cl_q[2];
			STEP_RING_D: step_part = cl_q[3];
			STEP_SPIN_A: step_part = cl_q[4];
			default:     step_part = cl_q[5];
		endcase
	end

	// A find waits only when it must hand its predecessor to a busy output.
	assign found_go = (nres_q >= NRES_W'(MAX_RES)) || !pend_valid_q || out_free;

	// Memory addressing and response pushes.
	always_comb begin
		bt_we      = 1'b0;
		bt_waddr   = {part_q, n_q[SLOT_W-1:0]};
		bt_wdata   = nb_q;
		bt_raddr   = {cand_q, j_q[SLOT_W-1:0]};
		cnt_we     = 1'b0;
		cnt_waddr  = part_q;
		cnt_wdata  = '0;
		cnt_raddr  = cand_q;
		lbl_we     = 1'b0;
		lbl_waddr  = step_part;
		lbl_wdata  = LBL_O;
		lbl_raddr  = step_part;
		push       = 1'b0;
		push_data  = '0;
		push_found = 1'b0;
		push_last  = 1'b1;
		unique case (state_q)
			ST_CLR: begin
				cnt_we    = 1'b1;
				cnt_waddr = clr_q;
				lbl_we    = 1'b1;
				lbl_waddr = clr_q;
				lbl_wdata = LBL_C;
			end
			ST_IDLE: begin
				cnt_raddr = in_part;
				lbl_raddr = in_part;
				if (accept) begin
					unique case (s_axis_tuser)
						OP_CLEAR: begin
							cnt_we    = 1'b1;
							cnt_waddr = in_part;
						end
						OP_RESET: begin
							lbl_we    = 1'b1;
							lbl_waddr = in_part;
							lbl_wdata = LBL_C;
						end
						OP_QUERY: cnt_raddr = in_cl[4];
						default: ;
					endcase
				end
			end
			ST_APP: begin
				if (cnt_rd_q < CNT_W'(MAX_BONDS)) begin
					bt_we     = 1'b1;
					bt_waddr  = {part_q, cnt_rd_q[SLOT_W-1:0]};
					cnt_we    = 1'b1;
					cnt_wdata = cnt_rd_q + CNT_W'(1);
				end
			end
			ST_QENT: begin
				bt_raddr  = {(sidx_q ? cl_q[5] : cl_q[4]), k_q[SLOT_W-1:0]};
				cnt_raddr = cl_q[5];
			end
			ST_QCAND: cnt_raddr = bt_rd_q;
			ST_QLWR: begin
				lbl_we = 1'b1;
				if (lstep_q <= STEP_RING_D) begin
					lbl_wdata = (lbl_rd_q == LBL_C) ? LBL_B : lbl_rd_q;
				end
			end
			ST_RESP: begin
				push = out_free;
				push_data = {TOTAL_W'(total_q), resp_ov_q, resp_lbl_q, 29'd0};
			end
			ST_QFOUND: begin
				if (nres_q < NRES_W'(MAX_RES) && pend_valid_q && out_free) begin
					push       = 1'b1;
					push_found = 1'b1;
					push_last  = 1'b0;
					push_data  = {pend_tot_q, 1'b0, LBL_C, pend_sp_q, pend_cand_q, qc_q};
				end
			end
			ST_QFIN: begin
				push = out_free;
				if (pend_valid_q) begin
					push_found = 1'b1;
					push_data  = {pend_tot_q, 1'b0, LBL_C, pend_sp_q, pend_cand_q, qc_q};
				end else begin
					push_data  = {total_q, 1'b0, LBL_C, 1'b0, 12'd0, qc_q};
				end
			end
			default: ;
		endcase
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (push) begin
			m_axis_tvalid <= 1'b1;
		end else if (m_axis_tready) begin
			m_axis_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			m_axis_tdata <= push_data;
			m_axis_tuser <= push_found;
			m_axis_tlast <= push_last;
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLR;
			clr_q        <= '0;
			total_q      <= '0;
			pend_valid_q <= 1'b0;
			nres_q       <= '0;
		end else begin
			unique case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + PART_W'(1);
					if (clr_q == PART_W'(MAX_PARTS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						part_q     <= in_part;
						nb_q       <= in_nb;
						qc_q       <= in_qc;
						for (int i = 0; i < 6; i++) begin
							cl_q[i] <= in_cl[i];
						end
						resp_lbl_q <= LBL_C;
						resp_ov_q  <= 1'b0;
						unique case (s_axis_tuser)
							OP_APPEND: state_q <= ST_APP;
							OP_READ:   state_q <= ST_LRD;
							OP_QUERY: begin
								sidx_q       <= 1'b0;
								nres_q       <= '0;
								pend_valid_q <= 1'b0;
								state_q      <= ST_QCNT;
							end
							default:   state_q <= ST_RESP;
						endcase
					end
				end
				ST_APP: begin
					resp_ov_q <= (cnt_rd_q >= CNT_W'(MAX_BONDS));
					state_q   <= ST_RESP;
				end
				ST_LRD: begin
					resp_lbl_q <= lbl_rd_q;
					state_q    <= ST_RESP;
				end
				ST_RESP: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				ST_QCNT: begin
					n_q     <= cnt_rd_q;
					k_q     <= '0;
					state_q <= ST_QENT;
				end
				ST_QENT: begin
					if (k_q < n_q) begin
						state_q <= ST_QCAND;
					end else if (!sidx_q) begin
						sidx_q  <= 1'b1;
						state_q <= ST_QCNT;
					end else begin
						state_q <= ST_QFIN;
					end
				end
				ST_QCAND: begin
					if (member) begin
						k_q     <= k_q + CNT_W'(1);
						state_q <= ST_QENT;
					end else begin
						cand_q  <= bt_rd_q;
						state_q <= ST_QCCNT;
					end
				end
				ST_QCCNT: begin
					cn_q    <= cnt_rd_q;
					j_q     <= '0;
					hit_q   <= '0;
					state_q <= ST_QWALK;
				end
				ST_QWALK: begin
					if (j_q < cn_q) begin
						state_q <= ST_QHIT;
					end else if ($countones(hit_q) == 2) begin
						lstep_q <= STEP_CAND;
						state_q <= ST_QLRD;
					end else begin
						k_q     <= k_q + CNT_W'(1);
						state_q <= ST_QENT;
					end
				end
				ST_QHIT: begin
					hit_q   <= hit_q | hit_now;
					j_q     <= j_q + CNT_W'(1);
					state_q <= ST_QWALK;
				end
				ST_QLRD: state_q <= ST_QLWR;
				ST_QLWR: begin
					if (lstep_q == STEP_SPIN_B) begin
						state_q <= ST_QFOUND;
					end else begin
						lstep_q <= lstep_q + STEP_W'(1);
						state_q <= ST_QLRD;
					end
				end
				ST_QFOUND: begin
					if (found_go) begin
						total_q <= total_inc;
						if (nres_q < NRES_W'(MAX_RES)) begin
							pend_valid_q <= 1'b1;
							pend_cand_q  <= cand_q;
							pend_sp_q    <= sidx_q;
							pend_tot_q   <= total_inc;
							nres_q       <= nres_q + NRES_W'(1);
						end
						k_q     <= k_q + CNT_W'(1);
						state_q <= ST_QENT;
					end
				end
				ST_QFIN: begin
					if (out_free) begin
						pend_valid_q <= 1'b0;
						state_q      <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_found_two_hits: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_QFOUND |-> $countones(hit_q) == 2)
		else $error("find without exactly two ring bonds");

	a_res_limit: assert property (@(posedge clk) disable iff (!arst_n)
		nres_q <= NRES_W'(MAX_RES))
		else $error("more finds recorded than can be reported");

	a_idle_no_pending: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !pend_valid_q)
		else $error("pending find left behind after a query");

	a_hit_after_walk: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_QHIT |-> $past(state_q) == ST_QWALK)
		else $error("bond compare without a bond read");
`endif

endmodule

// ===== test/bonded_cluster_extension_search_tb.sv =====
module bonded_cluster_extension_search_tb;
	import bces_pkg::*;

	// Operation codes that the block leaves unused: it answers them with a plain
	// response that carries only the find total.
	localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
	localparam logic [2:0] OP_SPARE_LAST  = 3'd7;

	localparam int POOL       = 40;       // particles used by the cluster scenarios
	localparam int PHASE_REQS = 50;       // random requests per idling phase
	localparam int DRAIN_WAIT = 200;      // cycles to watch for stray responses
	localparam longint CYCLE_LIMIT = 3000000;

	typedef struct {
		logic [2:0]           op;
		logic [PART_W-1:0]    part;
		logic [PART_W-1:0]    nb;
		logic [CLUSTER_W-1:0] cluster;
		logic [PART_W-1:0]    member [6];  // ring a..d, spindle a, spindle b
		bit                   hold;        // wait for all responses before sending
	} request_t;

	typedef struct {
		logic [CLUSTER_W-1:0] cluster;
		logic [PART_W-1:0]    extra;
		logic                 spindle;
		logic                 found;
		logic                 last;
		logic [LABEL_W-1:0]   label;
		logic                 overflow;
		logic [TOTAL_W-1:0]   total;
	} response_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
	logic [2:0]            s_axis_tuser = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  m_axis_tuser;
	logic                  m_axis_tlast;

	bonded_cluster_extension_search i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// Shadow copy of the block's bond lists, labels and find total.
	logic [PART_W-1:0]  bond_mem [0:MAX_PARTS*MAX_BONDS-1];
	logic [CNT_W-1:0]   bond_len [0:MAX_PARTS-1];
	logic [LABEL_W-1:0] shadow_label [0:MAX_PARTS-1];
	logic [TOTAL_W-1:0] find_total = '0;

	request_t  pending_q [$];
	response_t expected_q [$];
	request_t  sending;
	int        send_idle_pct = 0;
	int        recv_stall_pct = 0;
	bit        failed = 1'b0;
	longint    cycles = 0;

	initial begin
		for (int p = 0; p < MAX_PARTS; p++) begin
			bond_len[p] = '0;
			shadow_label[p] = LBL_C;
		end
	end

	function automatic bit is_bonded(logic [PART_W-1:0] p, logic [PART_W-1:0] q);
		for (int k = 0; k < bond_len[p]; k++)
			if (bond_mem[p*MAX_BONDS+k] == q)
				return 1'b1;
		return 1'b0;
	endfunction

	function automatic void mark_bonded(logic [PART_W-1:0] p);
		if (shadow_label[p] == LBL_C)
			shadow_label[p] = LBL_B;
	endfunction

	// Updates the shadow state for one accepted request and queues the responses
	// that it must produce.
	task automatic expect_responses(request_t rq);
		response_t rsp;
		logic [PART_W-1:0] spindle;
		logic [PART_W-1:0] cand;
		int reported;
		int hits;
		bit in_cluster;
		rsp = '{default: '0};
		rsp.last = 1'b1;
		case (rq.op)
			OP_CLEAR: begin
				bond_len[rq.part] = '0;
			end
			OP_APPEND: begin
				if (bond_len[rq.part] < MAX_BONDS) begin
					bond_mem[rq.part*MAX_BONDS+bond_len[rq.part]] = rq.nb;
					bond_len[rq.part] = bond_len[rq.part] + 1'b1;
				end else begin
					rsp.overflow = 1'b1;
				end
			end
			OP_READ: begin
				rsp.label = shadow_label[rq.part];
			end
			OP_RESET: begin
				shadow_label[rq.part] = LBL_C;
			end
			OP_QUERY: begin
				reported = 0;
				for (int s = 0; s < 2; s++) begin
					spindle = rq.member[4+s];
					for (int k = 0; k < bond_len[spindle]; k++) begin
						cand = bond_mem[spindle*MAX_BONDS+k];
						in_cluster = 1'b0;
						for (int i = 0; i < 6; i++)
							if (rq.member[i] == cand)
								in_cluster = 1'b1;
						if (in_cluster)
							continue;
						// A ring particle listed twice still counts once.
						hits = 0;
						for (int r = 0; r < 4; r++)
							if (is_bonded(cand, rq.member[r]))
								hits++;
						if (hits != 2)
							continue;
						mark_bonded(cand);
						for (int r = 0; r < 4; r++)
							mark_bonded(rq.member[r]);
						shadow_label[rq.member[4]] = LBL_O;
						shadow_label[rq.member[5]] = LBL_O;
						if (find_total != '1)
							find_total = find_total + 1'b1;
						// Finds beyond the response limit are counted but not reported.
						if (reported < MAX_RES) begin
							rsp.cluster = rq.cluster;
							rsp.extra = cand;
							rsp.spindle = s[0];
							rsp.found = 1'b1;
							rsp.last = 1'b0;
							rsp.total = find_total;
							expected_q.push_back(rsp);
							reported++;
						end
					end
				end
				if (reported > 0) begin
					expected_q[expected_q.size()-1].last = 1'b1;
					return;
				end
				rsp.cluster = rq.cluster;
			end
			default: begin
			end
		endcase
		rsp.total = find_total;
		expected_q.push_back(rsp);
	endtask

	// Driver: presents queued requests, with random gaps, and predicts each one
	// at the edge where it is accepted.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				expect_responses(sending);
			if (!s_axis_tvalid || s_axis_tready) begin
				if (pending_q.size() > 0 && !(pending_q[0].hold && expected_q.size() > 0)
						&& $urandom_range(99) >= send_idle_pct) begin
					sending = pending_q.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tuser <= sending.op;
					s_axis_tdata <= {sending.member[5], sending.member[4], sending.member[3],
						sending.member[2], sending.member[1], sending.member[0],
						sending.cluster, sending.nb, sending.part};
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n)
			m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Monitor: every response must match the oldest expectation field by field.
	always @(posedge clk) begin
		response_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected response tdata=%h tuser=%b tlast=%b",
					$time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
				failed = 1'b1;
			end else begin
				want = expected_q.pop_front();
				if (m_axis_tdata[15:0] !== want.cluster) begin
					$display("%0t: query_cluster expected %h actual %h",
						$time, want.cluster, m_axis_tdata[15:0]);
					failed = 1'b1;
				end
				if (m_axis_tdata[27:16] !== want.extra) begin
					$display("%0t: attached particle expected %h actual %h",
						$time, want.extra, m_axis_tdata[27:16]);
					failed = 1'b1;
				end
				if (m_axis_tdata[28] !== want.spindle) begin
					$display("%0t: spindle_used expected %b actual %b",
						$time, want.spindle, m_axis_tdata[28]);
					failed = 1'b1;
				end
				if (m_axis_tdata[30:29] !== want.label) begin
					$display("%0t: label expected %h actual %h",
						$time, want.label, m_axis_tdata[30:29]);
					failed = 1'b1;
				end
				if (m_axis_tdata[31] !== want.overflow) begin
					$display("%0t: overflow expected %b actual %b",
						$time, want.overflow, m_axis_tdata[31]);
					failed = 1'b1;
				end
				if (m_axis_tdata[47:32] !== want.total) begin
					$display("%0t: found_total expected %h actual %h",
						$time, want.total, m_axis_tdata[47:32]);
					failed = 1'b1;
				end
				if (m_axis_tuser !== want.found) begin
					$display("%0t: found expected %b actual %b",
						$time, want.found, m_axis_tuser);
					failed = 1'b1;
				end
				if (m_axis_tlast !== want.last) begin
					$display("%0t: last expected %b actual %b",
						$time, want.last, m_axis_tlast);
					failed = 1'b1;
				end
			end
		end
	end

	// The limit covers the clearing pass after reset and worst-case queries
	// under heavy stalls several times over.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("bonded_cluster_extension_search_tb NOT OK");
			$finish;
		end
	end

	int queued = 0;

	task automatic push_req(logic [2:0] op, logic [PART_W-1:0] part, logic [PART_W-1:0] nb,
			logic [CLUSTER_W-1:0] cluster, logic [PART_W-1:0] cl [6], bit hold);
		request_t rq;
		rq.op = op;
		rq.part = part;
		rq.nb = nb;
		rq.cluster = cluster;
		rq.member = cl;
		rq.hold = hold;
		pending_q.push_back(rq);
		queued++;
	endtask

	// A request with every field random, over the full widths.
	task automatic push_noise();
		logic [PART_W-1:0] cl [6];
		for (int i = 0; i < 6; i++)
			cl[i] = PART_W'($urandom_range(MAX_PARTS-1));
		push_req(3'($urandom_range(7)), PART_W'($urandom_range(MAX_PARTS-1)),
			PART_W'($urandom_range(MAX_PARTS-1)), CLUSTER_W'($urandom_range(65535)),
			cl, 1'b0);
	endtask

	// A well-formed cluster: spindle lists point at candidates, and candidates get
	// zero to three ring bonds, so some are finds and some are not. The query is
	// followed by label reads and resets on the same small pool of particles.
	task automatic push_cluster();
		logic [PART_W-1:0] cl [6];
		logic [PART_W-1:0] cands [$];
		logic [PART_W-1:0] c;
		logic [PART_W-1:0] none [6];
		int rings;
		none = '{default: '0};
		for (int i = 0; i < 6; i++)
			cl[i] = PART_W'($urandom_range(POOL-1));
		for (int s = 0; s < 2; s++) begin
			push_req(OP_CLEAR, cl[4+s], PART_W'($urandom_range(4095)), 0, none,
				$urandom_range(7) == 0);
			repeat ($urandom_range(3)) begin
				c = PART_W'($urandom_range(POOL-1));
				cands.push_back(c);
				push_req(OP_APPEND, cl[4+s], c, 0, none, 1'b0);
			end
		end
		foreach (cands[j]) begin
			push_req(OP_CLEAR, cands[j], 0, 0, none, 1'b0);
			rings = $urandom_range(7) < 5 ? 2 : $urandom_range(3);
			for (int r = 0; r < rings; r++)
				push_req(OP_APPEND, cands[j], cl[$urandom_range(3)], 0, none, 1'b0);
			if ($urandom_range(3) == 0)
				push_req(OP_APPEND, cands[j], PART_W'($urandom_range(POOL-1)), 0, none,
					1'b0);
		end
		push_req(OP_QUERY, PART_W'($urandom_range(4095)), PART_W'($urandom_range(4095)),
			CLUSTER_W'($urandom_range(65535)), cl, 1'b0);
		repeat ($urandom_range(1, 3))
			push_req(OP_READ, PART_W'($urandom_range(POOL-1)), 0, 0, none, 1'b0);
		if ($urandom_range(1) == 1)
			push_req(OP_RESET, PART_W'($urandom_range(POOL-1)), 0, 0, none, 1'b0);
		// Now and then append MAX_BONDS + 1 bonds, each to a random particle of the pool.
		if ($urandom_range(9) == 0)
			repeat (MAX_BONDS + 1)
				push_req(OP_APPEND, PART_W'($urandom_range(POOL-1)),
					PART_W'($urandom_range(POOL-1)), 0, none, 1'b0);
	endtask

	task automatic wait_idle();
		do
			@(posedge clk);
		while (pending_q.size() > 0 || s_axis_tvalid || expected_q.size() > 0);
	endtask

	initial begin
		logic [PART_W-1:0] none [6];
		logic [PART_W-1:0] top [6];
		logic [PART_W-1:0] cl [6];
		int send_phase [4];
		int recv_phase [4];
		none = '{default: '0};
		top = '{default: 12'hFFF};
		cl = '{12'd1, 12'd2, 12'd3, 12'd4, 12'd5, 12'd6};
		send_phase = '{0, 58, 0, 20};
		recv_phase = '{0, 0, 58, 20};

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: unused codes, the highest particle number and cluster index,
		// a query with no find, a repeated neighbour in a spindle list and a ring
		// particle listed twice in the candidate's list.
		for (int op = OP_SPARE_FIRST; op <= OP_SPARE_LAST; op++)
			push_req(3'(op), 12'hFFF, 12'hFFF, 16'hFFFF, top, 1'b0);
		push_req(OP_READ, 12'hFFF, 0, 0, none, 1'b0);
		push_req(OP_CLEAR, 12'hFFF, 0, 0, none, 1'b0);
		push_req(OP_APPEND, 12'hFFF, 12'hFFF, 0, none, 1'b0);
		push_req(OP_QUERY, 12'hFFF, 12'hFFF, 16'hFFFF, top, 1'b0);
		push_req(OP_RESET, 12'hFFF, 0, 0, none, 1'b0);
		push_req(OP_CLEAR, 5, 0, 0, none, 1'b0);
		push_req(OP_APPEND, 5, 7, 0, none, 1'b0);
		push_req(OP_APPEND, 5, 7, 0, none, 1'b0);
		push_req(OP_CLEAR, 7, 0, 0, none, 1'b0);
		push_req(OP_APPEND, 7, 1, 0, none, 1'b0);
		push_req(OP_APPEND, 7, 1, 0, none, 1'b0);
		push_req(OP_APPEND, 7, 2, 0, none, 1'b0);
		// This query waits until the block has answered everything before it.
		push_req(OP_QUERY, 0, 0, 16'hFFFF, cl, 1'b1);
		push_req(OP_READ, 7, 0, 0, none, 1'b0);
		push_req(OP_READ, 5, 0, 0, none, 1'b0);
		push_req(OP_READ, 1, 0, 0, none, 1'b0);
		push_req(OP_RESET, 7, 0, 0, none, 1'b0);
		push_req(OP_READ, 7, 0, 0, none, 1'b0);

		// Random part, one idling setting per phase.
		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = send_phase[ph];
			recv_stall_pct = recv_phase[ph];
			queued = 0;
			while (queued < PHASE_REQS) begin
				if ($urandom_range(4) == 0)
					push_noise();
				else
					push_cluster();
			end
			wait_idle();
		end

		repeat (DRAIN_WAIT) @(posedge clk);
		if (!failed && expected_q.size() == 0)
			$display("bonded_cluster_extension_search_tb OK");
		else
			$display("bonded_cluster_extension_search_tb NOT OK");
		$finish;
	end

endmodule
